[hw/rtl/crcgc_pkg.sv]
package crcgc_pkg;

	localparam int MAX_DEGREE = 32;
	localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
	localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int Q_DEPTH    = 4;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_POLY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	typedef struct packed {
		logic data_bit;
		logic last_bit;
	} in_item_t;

	typedef struct packed {
		logic out_bit;
		logic is_check_bit;
		logic out_last;
		logic error_flag;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_ECHO,
		CMD_DUMP,
		CMD_CHECK
	} cmd_t;

	// one queued job for the back end
	typedef struct packed {
		cmd_t                  cmd;
		logic                  bit_val;
		logic [MAX_DEGREE-1:0] rem;
		logic [DEG_W-1:0]      deg;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic {
		BK_IDLE,
		BK_DUMP
	} bk_state_t;

	// degree 0 acts as 1, above the maximum saturates
	function automatic logic [DEG_W-1:0] eff_deg(input logic [DEG_W-1:0] d);
		logic [DEG_W-1:0] r;
		r = d;
		if (d == '0)
			r = DEG_W'(1);
		else if (d > DEG_W'(MAX_DEGREE))
			r = DEG_W'(MAX_DEGREE);
		return r;
	endfunction

	function automatic logic [MAX_DEGREE-1:0] deg_mask(input logic [DEG_W-1:0] d);
		logic [MAX_DEGREE-1:0] m;
		for (int i = 0; i < MAX_DEGREE; i++)
			m[i] = (DEG_W'(i) < d);
		return m;
	endfunction

endpackage

[hw/rtl/crcgc_front.sv]
module crcgc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  crcgc_pkg::in_item_t            item,
	input  logic                           cfg_we,
	input  logic [crcgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcgc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  crcgc_pkg::q_status_t           q_status,
	output logic                           push,
	output crcgc_pkg::job_t                push_job
);
	import crcgc_pkg::*;

	logic [MAX_DEGREE-1:0] poly_q;
	logic [DEG_W-1:0]      degree_q;
	logic                  mode_q;
	logic [MAX_DEGREE-1:0] rem_q;

	logic [DEG_W-1:0]      d;
	logic [IDX_W-1:0]      msb_idx;
	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] rem;
	logic [MAX_DEGREE-1:0] rem_nxt;
	logic                  fb;
	logic                  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= MAX_DEGREE'(3);
			degree_q <= DEG_W'(3);
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLY:   poly_q   <= cfg_data[MAX_DEGREE-1:0];
				REG_DEGREE: degree_q <= cfg_data[DEG_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	assign item_stall = q_status.full;
	assign accept     = item_valid && !q_status.full;

	always_comb begin
		d       = eff_deg(degree_q);
		msb_idx = IDX_W'(d - DEG_W'(1));
		mask    = deg_mask(d);
		rem     = rem_q & mask;
		fb      = rem[msb_idx] ^ item.data_bit;
		rem_nxt = (rem << 1) & mask;
		if (fb)
			rem_nxt = rem_nxt ^ (poly_q & mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= item.last_bit ? '0 : rem_nxt;
		end
	end

	// check mode only reports at the end of the codeword
	always_comb begin
		push_job.bit_val = item.data_bit;
		push_job.rem     = rem_nxt;
		push_job.deg     = d;
		push_job.cmd     = CMD_ECHO;
		push             = 1'b0;
		if (mode_q) begin
			push_job.cmd     = CMD_CHECK;
			push_job.bit_val = (rem_nxt != '0);
			push             = accept && item.last_bit;
		end else begin
			push_job.cmd = item.last_bit ? CMD_DUMP : CMD_ECHO;
			push         = accept;
		end
	end

endmodule

[hw/rtl/crcgc_queue.sv]
module crcgc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crcgc_pkg::job_t      push_job,
	input  logic                 pop,
	output crcgc_pkg::job_t      head,
	output crcgc_pkg::q_status_t status
);
	import crcgc_pkg::*;

	job_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[hw/rtl/crcgc_back.sv]
module crcgc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcgc_pkg::job_t      head,
	input  crcgc_pkg::q_status_t q_status,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output crcgc_pkg::out_item_t result
);
	import crcgc_pkg::*;

	bk_state_t             state_q;
	bk_state_t             state_nxt;
	logic [MAX_DEGREE-1:0] rem_q;
	logic [DEG_W-1:0]      cnt_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  adv;
	logic                  emit;
	out_item_t             out_nxt;
	logic [IDX_W-1:0]      bit_idx;

	assign adv          = !out_valid_q || !result_stall;
	assign bit_idx      = IDX_W'(cnt_q - DEG_W'(1));
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (adv && !q_status.empty && head.cmd == CMD_DUMP)
					state_nxt = BK_DUMP;
			end
			BK_DUMP: begin
				if (adv && cnt_q == DEG_W'(1))
					state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		emit    = 1'b0;
		out_nxt = '0;
		unique case (state_q)
			BK_IDLE: begin
				pop  = adv && !q_status.empty;
				emit = !q_status.empty;
				unique case (head.cmd)
					CMD_CHECK: begin
						out_nxt.out_last   = 1'b1;
						out_nxt.error_flag = head.bit_val;
					end
					default: out_nxt.out_bit = head.bit_val;
				endcase
			end
			BK_DUMP: begin
				emit                 = 1'b1;
				out_nxt.out_bit      = rem_q[bit_idx];
				out_nxt.is_check_bit = 1'b1;
				out_nxt.out_last     = (cnt_q == DEG_W'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_nxt;
			if (adv)
				out_valid_q <= emit;
			if (pop && head.cmd == CMD_DUMP)
				cnt_q <= head.deg;
			else if (state_q == BK_DUMP && adv)
				cnt_q <= cnt_q - DEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= out_nxt;
		if (pop && head.cmd == CMD_DUMP)
			rem_q <= head.rem;
	end

endmodule

[hw/rtl/crc_generate_and_check.sv]
// Bit-serial CRC generator and checker with a programmable generator polynomial of degree
// 1 to 32 (implicit leading one). One bit request is taken per clock while item_stall is low; the remainder
// update in the front end is a single shift and conditional xor, so a plain message streams at one bit per
// cycle with one echoed result per cycle while neither stall is raised. In generate mode the last bit is
// followed by poly_degree check bits, MSB first, which the back end shifts out one per cycle while
// result_stall is low, so a message of N bits yields N + poly_degree results; a four-entry job queue
// between front and back lets new bits arrive while check bits drain, after which item_stall rises until
// it has room. In check mode only the last codeword bit yields a result, carrying error_flag. Configuration
// takes effect at once and should be written between messages; no clearing pass after reset.
module crc_generate_and_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  crcgc_pkg::in_item_t              item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output crcgc_pkg::out_item_t             result,
	input  logic                             cfg_we,
	input  logic [crcgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcgc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import crcgc_pkg::*;

	q_status_t q_status;
	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head;

	crcgc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	crcgc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	crcgc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[hw/rtl/crcgc_checker.sv]
module crcgc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  crcgc_pkg::out_item_t result
);
	import crcgc_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// check bits never carry an error flag
	a_chk_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_check_bit |-> !result.error_flag)
		else $error("error flag on a check bit");

	// an error report is the closing result of a run with a zero data bit
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_flag |-> result.out_last && !result.out_bit)
		else $error("error flag outside a check report");

	// after an accepted result with out_last and a check bit, the next result is not a check bit
	// unless a new run started
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.out_last && result.is_check_bit
		&& !(item_valid && !item_stall) |=> !(result_valid && result.is_check_bit))
		else $error("check bits continue past end of run");

endmodule

bind crc_generate_and_check crcgc_checker u_crcgc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[test/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crcgc_pkg::*;

	localparam logic MODE_GENERATE = 1'b0;
	localparam logic MODE_CHECK    = 1'b1;

	typedef bit bitq_t[$];

	// running division and the results it must produce, in order
	class crc_predictor;
		logic [31:0] poly_low;
		logic [5:0]  degree;
		logic        mode;
		logic [31:0] remainder;
		out_item_t   pending_results[$];
		int          mismatches;

		function new();
			poly_low   = 32'd3;
			degree     = 6'd3;
			mode       = MODE_GENERATE;
			remainder  = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_POLY: begin
					poly_low = data;
				end
				REG_DEGREE: begin
					degree = data[5:0];
				end
				REG_MODE: begin
					mode = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		// degree 0 acts as 1, above the maximum saturates
		function int width();
			if (degree == 6'd0)
				return 1;
			if (degree > MAX_DEGREE)
				return MAX_DEGREE;
			return int'(degree);
		endfunction

		function logic [31:0] shift_in(logic [31:0] rem, logic b);
			int          d;
			logic [31:0] mask;
			logic        fb;
			d    = width();
			mask = (d == 32) ? '1 : ((32'd1 << d) - 32'd1);
			rem  = rem & mask;
			fb   = rem[d-1] ^ b;
			rem  = (rem << 1) & mask;
			if (fb)
				rem = rem ^ (poly_low & mask);
			return rem;
		endfunction

		function void accept_bit(in_item_t it);
			logic [31:0] rem;
			out_item_t   r;
			rem       = shift_in(remainder, it.data_bit);
			remainder = rem;
			if (mode == MODE_GENERATE) begin
				r = '{out_bit: it.data_bit, is_check_bit: 1'b0, out_last: 1'b0, error_flag: 1'b0};
				pending_results.push_back(r);
				if (it.last_bit) begin
					for (int k = width() - 1; k >= 0; k--) begin
						r = '{out_bit: rem[k], is_check_bit: 1'b1, out_last: (k == 0),
							error_flag: 1'b0};
						pending_results.push_back(r);
					end
					remainder = '0;
				end
			end else if (it.last_bit) begin
				r = '{out_bit: 1'b0, is_check_bit: 1'b0, out_last: 1'b1, error_flag: (rem != '0)};
				pending_results.push_back(r);
				remainder = '0;
			end
		endfunction

		function void compare_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("result %b with no request pending", got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.out_bit !== want.out_bit) begin
				$error("out_bit expected %0b actual %0b", want.out_bit, got.out_bit);
				mismatches++;
			end
			if (got.is_check_bit !== want.is_check_bit) begin
				$error("is_check_bit expected %0b actual %0b", want.is_check_bit, got.is_check_bit);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last expected %0b actual %0b", want.out_last, got.out_last);
				mismatches++;
			end
			if (got.error_flag !== want.error_flag) begin
				$error("error_flag expected %0b actual %0b", want.error_flag, got.error_flag);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_stall;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	crc_predictor board;
	bit           quiet;
	int           sent_random;

	crc_generate_and_check u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

	// receiver back-pressure in short bursts
	initial begin
		int stall_left;
		stall_left   = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.compare_result(result);
	end

	task automatic send_request(logic d, logic l);
		in_item_t it;
		int       gap;
		it.data_bit = d;
		it.last_bit = l;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		board.accept_bit(it);
	endtask

	task automatic send_message(bitq_t msg);
		foreach (msg[i])
			send_request(msg[i], i == msg.size() - 1);
	endtask

	// hold the sender until every pending result is out, then let the block settle
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// message followed by its check bits, msb first
	function automatic bitq_t make_codeword(bitq_t msg);
		logic [31:0] rem;
		rem = '0;
		foreach (msg[i])
			rem = board.shift_in(rem, msg[i]);
		for (int k = board.width() - 1; k >= 0; k--)
			msg.push_back(rem[k]);
		return msg;
	endfunction

	initial begin
		bitq_t       msg;
		bitq_t       cw;
		int          deg_pick[11];
		int          phase;
		int          target;
		int          count;
		int          len;
		int          shape;
		int          j;
		logic [31:0] poly;
		logic [5:0]  deg;
		logic        mode;

		deg_pick    = '{0, 1, 2, 3, 5, 8, 16, 31, 32, 33, 63};
		board       = new();
		quiet       = 1'b0;
		sent_random = 0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: generate with x^3 + x + 1
		msg = '{1, 0, 1, 1};
		send_message(msg);
		msg = '{1};
		send_message(msg);
		msg = '{0};
		send_message(msg);
		drain();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_CHECK));
		msg = '{1, 1, 0, 1};
		send_message(make_codeword(msg));
		msg = '{1};
		cw  = make_codeword(msg);
		cw[0] = ~cw[0];
		send_message(cw);

		phase = 0;
		while (sent_random < 230) begin
			if (phase < 11) begin
				deg  = 6'(deg_pick[phase]);
				mode = phase[0];
			end else begin
				deg  = 6'($urandom_range(0, 63));
				mode = 1'($urandom_range(0, 1));
			end
			case ($urandom_range(0, 3))
				0: poly = '0;
				1: poly = '1;
				default: poly = $urandom;
			endcase
			drain();
			write_reg(REG_POLY, poly);
			write_reg(REG_DEGREE, CFG_DATA_W'(deg));
			write_reg(REG_MODE, CFG_DATA_W'(mode));

			target = $urandom_range(15, 30);
			count  = 0;
			while (count < target) begin
				quiet = (sent_random >= 190);
				len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
				shape = $urandom_range(0, 5);
				msg.delete();
				for (int i = 0; i < len; i++) begin
					if (shape == 0)
						msg.push_back(1'b0);
					else if (shape == 1)
						msg.push_back(1'b1);
					else
						msg.push_back(1'($urandom_range(0, 1)));
				end
				// in check mode mostly clean codewords, some with one bit hit, some noise
				if (mode == MODE_CHECK && $urandom_range(0, 7) != 0) begin
					cw = make_codeword(msg);
					if ($urandom_range(0, 3) == 0) begin
						j     = $urandom_range(0, cw.size() - 1);
						cw[j] = ~cw[j];
					end
				end else begin
					cw = msg;
				end
				send_message(cw);
				count       += cw.size();
				sent_random += cw.size();
			end
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
